@@ rtl/core/clbc_pkg.sv @@
// Shared types, constants and helper functions for the card number check.
// No dependencies; every other file of the block imports this package.
package clbc_pkg;

   // Card number width and the decimal digits it can hold.
   localparam int CARD_W     = 54;
   localparam int NUM_DIGITS = 17;
   localparam int BCD_W      = 4 * NUM_DIGITS;

   // Binary to decimal conversion: bits shifted in per pipeline stage.
   localparam int DAB_BITS   = 6;
   localparam int DAB_STAGES = CARD_W / DAB_BITS;

   // Longest accepted number; longer ones are flagged.
   localparam int MAX_DIGITS = 16;

   localparam logic [4:0] DIGIT_LIMIT = 5'(MAX_DIGITS);
   localparam logic [4:0] COUNT_OVER  = 5'(MAX_DIGITS + 1);

   // Brand codes.
   localparam logic [1:0] BRAND_NONE = 2'd0;
   localparam logic [1:0] BRAND_AMEX = 2'd1;
   localparam logic [1:0] BRAND_MC   = 2'd2;
   localparam logic [1:0] BRAND_VISA = 2'd3;

   // Card lengths that carry a brand.
   localparam logic [4:0] LEN_VISA_SHORT = 5'd13;
   localparam logic [4:0] LEN_AMEX       = 5'd15;
   localparam logic [4:0] LEN_LONG       = 5'd16;

   typedef logic [CARD_W-1:0] card_type;
   typedef logic [BCD_W-1:0]  bcd_type;
   typedef logic [3:0]        digit_type;

   // Value a digit in an even position adds to the sum.
   function automatic logic [3:0] luhn_double(input digit_type d);
      logic [4:0] dd;
      dd = {d, 1'b0};
      if (dd >= 5'd10) begin
         luhn_double = 4'(dd - 5'd9);
      end else begin
         luhn_double = dd[3:0];
      end
   endfunction

   // True when a sum of at most 255 is a multiple of ten.
   function automatic logic is_mult10(input logic [7:0] s);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= 25; k++) begin
         if (s == 8'(10 * k)) begin
            hit = 1'b1;
         end
      end
      is_mult10 = hit;
   endfunction

endpackage

@@ rtl/core/clbc_dabble.sv @@
// One stage of the binary to decimal conversion pipeline.
// Shifts DAB_BITS bits of the card number into the decimal digits; uses clbc_pkg.
module clbc_dabble
   import clbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  card_type in_bin,
   input  bcd_type  in_bcd,
   output logic     out_valid,
   input  logic     out_ready,
   output card_type out_bin,
   output bcd_type  out_bcd
);

   logic     valid_ff;
   logic     valid_in;
   card_type bin_ff;
   card_type bin_in;
   bcd_type  bcd_ff;
   bcd_type  bcd_in;
   logic     load;

   // The stage takes a new beat when it is empty or its beat moves on.
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;
   assign valid_in = load ? in_valid : valid_ff;

   // Shift-and-add-three over the bits of this stage, MSB first.
   always_comb begin
      card_type bin_work;
      bcd_type  bcd_work;
      bin_work = in_bin;
      bcd_work = in_bcd;
      for (int b = 0; b < DAB_BITS; b++) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_work[4*i +: 4] >= 4'd5) begin
               bcd_work[4*i +: 4] = bcd_work[4*i +: 4] + 4'd3;
            end
         end
         bcd_work = {bcd_work[BCD_W-2:0], bin_work[CARD_W-1]};
         bin_work = {bin_work[CARD_W-2:0], 1'b0};
      end
      bin_in = bin_work;
      bcd_in = bcd_work;
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bin   = bin_ff;
   assign out_bcd   = bcd_ff;

endmodule

@@ rtl/core/card_number_luhn_brand_check.sv @@
// Card number Luhn check with brand recognition: top level.
// Throughput: one card number per cycle while rsp_ready is high; the depth is set
// by converting 54 bits to decimal six bits per stage, then one stage for count
// and sums, one for checks.
// Reset clears all valid bits; data registers are not reset.
// Uses clbc_pkg and clbc_dabble.
module card_number_luhn_brand_check
   import clbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [53:0] req_card_number,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_brand,
   output logic       rsp_luhn_ok,
   output logic [4:0] rsp_digit_count,
   output logic [7:0] rsp_luhn_sum,
   output logic       rsp_too_long
);

   // Conversion pipeline links; index 0 is the input side.
   logic     stg_valid [DAB_STAGES+1];
   logic     stg_ready [DAB_STAGES+1];
   card_type stg_bin   [DAB_STAGES+1];
   bcd_type  stg_bcd   [DAB_STAGES+1];

   assign stg_valid[0] = req_valid;
   assign stg_bin[0]   = req_card_number;
   assign stg_bcd[0]   = '0;
   assign req_ready    = stg_ready[0];

   for (genvar s = 0; s < DAB_STAGES; s++) begin : g_dabble
      clbc_dabble u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_bin    (stg_bin[s]),
         .in_bcd    (stg_bcd[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_bin   (stg_bin[s+1]),
         .out_bcd   (stg_bcd[s+1])
      );
   end

   // Count and sum stage registers.
   logic       a_valid_ff;
   logic       a_valid_in;
   logic       a_load;
   bcd_type    a_bcd_ff;
   logic [4:0] a_count_ff;
   logic [4:0] a_count_in;
   logic [6:0] a_sum_lo_ff;
   logic [6:0] a_sum_lo_in;
   logic [6:0] a_sum_hi_ff;
   logic [6:0] a_sum_hi_in;

   // Result stage registers.
   logic       b_valid_ff;
   logic       b_valid_in;
   logic       b_load;
   logic [1:0] b_brand_ff;
   logic [1:0] b_brand_in;
   logic       b_ok_ff;
   logic       b_ok_in;
   logic [4:0] b_count_ff;
   logic [4:0] b_count_in;
   logic [7:0] b_sum_ff;
   logic [7:0] b_sum_in;
   logic       b_long_ff;
   logic       b_long_in;

   // Handshake chain of the last two stages.
   assign b_load = !b_valid_ff || rsp_ready;
   assign a_load = !a_valid_ff || b_load;
   assign stg_ready[DAB_STAGES] = a_load;
   assign a_valid_in = a_load ? stg_valid[DAB_STAGES] : a_valid_ff;
   assign b_valid_in = b_load ? a_valid_ff : b_valid_ff;

   // Digit count from the highest nonzero digit, and the two half sums.
   always_comb begin
      bcd_type    d;
      logic [4:0] cnt;
      logic [6:0] lo;
      logic [6:0] hi;
      logic [3:0] term;
      d   = stg_bcd[DAB_STAGES];
      cnt = 5'd1;
      lo  = '0;
      hi  = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (d[4*i +: 4] != 4'd0) begin
            cnt = 5'(i + 1);
         end
         if ((i % 2) == 1) begin
            term = luhn_double(d[4*i +: 4]);
         end else begin
            term = d[4*i +: 4];
         end
         if (i < (NUM_DIGITS + 1) / 2) begin
            lo = lo + 7'(term);
         end else begin
            hi = hi + 7'(term);
         end
      end
      a_count_in  = cnt;
      a_sum_lo_in = lo;
      a_sum_hi_in = hi;
   end

   // Final sum, modulo ten test and brand from the leading digits; an overlong number clears them.
   always_comb begin
      logic [7:0] sum;
      logic       ok;
      logic       long_num;
      logic [1:0] brand;
      digit_type  d12;
      digit_type  d13;
      digit_type  d14;
      digit_type  d15;
      sum      = 8'(a_sum_lo_ff) + 8'(a_sum_hi_ff);
      long_num = a_count_ff > DIGIT_LIMIT;
      d12      = a_bcd_ff[4*12 +: 4];
      d13      = a_bcd_ff[4*13 +: 4];
      d14      = a_bcd_ff[4*14 +: 4];
      d15      = a_bcd_ff[4*15 +: 4];
      ok       = is_mult10(sum);
      brand    = BRAND_NONE;
      if (a_count_ff == LEN_AMEX) begin
         if (d14 == 4'd3 && (d13 == 4'd4 || d13 == 4'd7)) begin
            brand = BRAND_AMEX;
         end
      end else if (a_count_ff == LEN_LONG) begin
         if (d15 == 4'd5 && d14 >= 4'd1 && d14 <= 4'd5) begin
            brand = BRAND_MC;
         end else if (d15 == 4'd4) begin
            brand = BRAND_VISA;
         end
      end else if (a_count_ff == LEN_VISA_SHORT) begin
         if (d12 == 4'd4) begin
            brand = BRAND_VISA;
         end
      end
      if (long_num) begin
         b_sum_in   = '0;
         b_ok_in    = 1'b0;
         b_brand_in = BRAND_NONE;
         b_count_in = COUNT_OVER;
      end else begin
         b_sum_in   = sum;
         b_ok_in    = ok;
         b_brand_in = ok ? brand : BRAND_NONE;
         b_count_in = a_count_ff;
      end
      b_long_in = long_num;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Payload of the count and sum stage.
   always_ff @(posedge clock) begin
      if (a_load && stg_valid[DAB_STAGES]) begin
         a_bcd_ff    <= stg_bcd[DAB_STAGES];
         a_count_ff  <= a_count_in;
         a_sum_lo_ff <= a_sum_lo_in;
         a_sum_hi_ff <= a_sum_hi_in;
      end
   end

   // Payload of the result stage.
   always_ff @(posedge clock) begin
      if (b_load && a_valid_ff) begin
         b_brand_ff <= b_brand_in;
         b_ok_ff    <= b_ok_in;
         b_count_ff <= b_count_in;
         b_sum_ff   <= b_sum_in;
         b_long_ff  <= b_long_in;
      end
   end

   assign rsp_valid       = b_valid_ff;
   assign rsp_brand       = b_brand_ff;
   assign rsp_luhn_ok     = b_ok_ff;
   assign rsp_digit_count = b_count_ff;
   assign rsp_luhn_sum    = b_sum_ff;
   assign rsp_too_long    = b_long_ff;

   // A brand is only reported for a number that passed the sum test.
   a_brand_needs_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brand != BRAND_NONE |-> rsp_luhn_ok && !rsp_too_long)
      else $error("brand reported without a passing Luhn sum");

   // A brand is only reported for one of the branded lengths.
   a_brand_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brand != BRAND_NONE |->
         rsp_digit_count == LEN_VISA_SHORT || rsp_digit_count == LEN_AMEX ||
         rsp_digit_count == LEN_LONG)
      else $error("brand reported for a length without a brand");

   // An overlong number reports the saturated count and a cleared sum.
   a_long_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_digit_count == COUNT_OVER && rsp_luhn_sum == 8'd0)
      else $error("overlong number with wrong count or sum");

endmodule
